[hw/rtl/bhpq_pkg.sv]
// Shared types, codes and default sizes of the binary heap priority queue.
`default_nettype none
package bhpq_pkg;

	localparam int unsigned CAPACITY_DEF  = 1024;
	localparam int unsigned KEY_BITS_DEF  = 32;
	localparam int unsigned TAG_BITS      = 10;
	localparam int unsigned TAG_SPACE     = 1024;
	localparam int unsigned KEY_PORT_BITS = 32;
	localparam int unsigned CNT_PORT_BITS = 11;

	typedef enum logic [1:0] {
		FN_INSERT      = 2'd0,
		FN_REMOVE_TAG  = 2'd1,
		FN_REMOVE_ROOT = 2'd2,
		FN_READ        = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2,
		ST_DUP  = 2'd3
	} status_t;

	// Operation class decided by the front end, one-hot.
	typedef enum logic [3:0] {
		OP_INSERT      = 4'b0001,
		OP_REMOVE_TAG  = 4'b0010,
		OP_REMOVE_ROOT = 4'b0100,
		OP_READ        = 4'b1000
	} op_t;

	typedef struct packed {
		func_t                     func;
		logic [KEY_PORT_BITS-1:0]  entry_key;
		logic [TAG_BITS-1:0]       entry_tag;
		logic [TAG_BITS-1:0]       heap_index;
	} item_t;

	typedef struct packed {
		status_t                   status;
		logic [KEY_PORT_BITS-1:0]  out_key;
		logic [TAG_BITS-1:0]       out_tag;
		logic [CNT_PORT_BITS-1:0]  fill_count;
	} res_t;

	typedef struct packed {
		op_t                       op;
		logic [KEY_PORT_BITS-1:0]  key;
		logic [TAG_BITS-1:0]       tag;
		logic [TAG_BITS-1:0]       idx;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} eng_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/bhpq_front.sv]
// Front end: accepts requests, classifies them and queues them for the engine.
`default_nettype none
module bhpq_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  bhpq_pkg::item_t     item,
	input  bhpq_pkg::eng_ctl_t  ctl,
	output logic                cmd_valid,
	output bhpq_pkg::cmd_t      cmd,
	input  wire                 cmd_take
);

	bhpq_pkg::cmd_t ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       acc;
	bhpq_pkg::cmd_t cls;

	always_comb begin
		cls.key = item.entry_key;
		cls.tag = item.entry_tag;
		cls.idx = item.heap_index;
		case (item.func)
			bhpq_pkg::FN_INSERT:      cls.op = bhpq_pkg::OP_INSERT;
			bhpq_pkg::FN_REMOVE_TAG:  cls.op = bhpq_pkg::OP_REMOVE_TAG;
			bhpq_pkg::FN_REMOVE_ROOT: cls.op = bhpq_pkg::OP_REMOVE_ROOT;
			bhpq_pkg::FN_READ:        cls.op = bhpq_pkg::OP_READ;
			default:                  cls.op = bhpq_pkg::OP_READ;
		endcase
	end

	// No request is taken while the engine clears its tag table.
	assign full      = (cnt_q == 2'd2) || ctl.clearing;
	assign acc       = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (acc) begin
			ent_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) begin
				wr_q <= ~wr_q;
			end
			if (cmd_take) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, acc} - {1'b0, cmd_take};
		end
	end

endmodule
`default_nettype wire

[hw/rtl/bhpq_engine.sv]
// Back end: heap memories and the sequencer that performs sift up and sift down.
`default_nettype none
module bhpq_engine #(
	parameter int unsigned CAPACITY = bhpq_pkg::CAPACITY_DEF,
	parameter int unsigned KEY_BITS = bhpq_pkg::KEY_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 order,
	input  wire                 cmd_valid,
	input  bhpq_pkg::cmd_t      cmd,
	output logic                cmd_take,
	output bhpq_pkg::eng_ctl_t  ctl,
	output logic                empty,
	input  wire                 pop,
	output bhpq_pkg::res_t      result
);

	localparam int unsigned PW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned KB = (KEY_BITS < bhpq_pkg::KEY_PORT_BITS) ? KEY_BITS
		: bhpq_pkg::KEY_PORT_BITS;
	localparam int unsigned TB = bhpq_pkg::TAG_BITS;

	typedef enum logic [9:0] {
		S_CLEAR  = 10'b0000000001,
		S_IDLE   = 10'b0000000010,
		S_LOOK   = 10'b0000000100,
		S_RM_ISS = 10'b0000001000,
		S_RM_DAT = 10'b0000010000,
		S_UP_ISS = 10'b0000100000,
		S_UP_DAT = 10'b0001000000,
		S_DN_ISS = 10'b0010000000,
		S_DN_DAT = 10'b0100000000,
		S_PLACE  = 10'b1000000000
	} state_t;

	logic [KB-1:0] key_mem  [CAPACITY];
	logic [TB-1:0] tag_mem  [CAPACITY];
	logic [PW-1:0] pos_mem  [bhpq_pkg::TAG_SPACE];
	logic          pres_mem [bhpq_pkg::TAG_SPACE];

	state_t          state_q;
	bhpq_pkg::cmd_t  cmd_q;
	logic [CW-1:0]   count_q;
	logic [PW-1:0]   pos_q;
	logic [KB-1:0]   ck_q;
	logic [TB-1:0]   ct_q;
	logic            moved_q;
	logic [TB-1:0]   clr_q;
	bhpq_pkg::res_t  res_q;
	logic            res_valid_q;

	logic [KB-1:0] ka_q, kb_q;
	logic [TB-1:0] ta_q, tb_q;
	logic [PW-1:0] posrd_q;
	logic          presrd_q;

	logic [PW-1:0] addr_a, addr_b;
	logic          heap_we;
	logic [PW-1:0] heap_waddr;
	logic [KB-1:0] heap_wkey;
	logic [TB-1:0] heap_wtag;
	logic          pres_we;
	logic [TB-1:0] pres_waddr;
	logic          pres_wdata;

	logic [PW-1:0] last;
	logic [PW-1:0] par;
	logic [PW+1:0] child_a, child_b, n_ext;
	logic          in_a, pick_b, is_remove, go_down;
	logic [KB-1:0] ckey;
	logic [TB-1:0] ctag;
	logic [PW-1:0] cpos;

	function automatic logic above(input logic [KB-1:0] a, input logic [KB-1:0] b,
		input logic ord);
		above = ord ? (a >= b) : (a <= b);
	endfunction

	assign last      = PW'(count_q - CW'(1));
	assign par       = PW'((pos_q - PW'(1)) >> 1);
	assign child_a   = {1'b0, pos_q, 1'b1};
	assign child_b   = child_a + (PW+2)'(1);
	assign n_ext     = (PW+2)'(count_q);
	assign in_a      = child_a < n_ext;
	assign pick_b    = (child_b < n_ext) && above(kb_q, ka_q, order);
	assign ckey      = pick_b ? kb_q : ka_q;
	assign ctag      = pick_b ? tb_q : ta_q;
	assign cpos      = pick_b ? child_b[PW-1:0] : child_a[PW-1:0];
	assign is_remove = (cmd_q.op != bhpq_pkg::OP_INSERT);
	// A removal whose filler did not climb continues downward.
	assign go_down   = is_remove && !moved_q;

	assign cmd_take     = (state_q == S_IDLE) && cmd_valid && !res_valid_q;
	assign ctl.clearing = (state_q == S_CLEAR);
	assign empty        = !res_valid_q;
	assign result       = res_q;

	always_comb begin
		addr_a     = PW'(cmd.idx);
		addr_b     = last;
		heap_we    = 1'b0;
		heap_waddr = pos_q;
		heap_wkey  = ck_q;
		heap_wtag  = ct_q;
		pres_we    = 1'b0;
		pres_waddr = cmd_q.tag;
		pres_wdata = 1'b0;
		case (state_q)
			S_CLEAR: begin
				pres_we    = 1'b1;
				pres_waddr = clr_q;
			end
			S_LOOK: begin
				if (cmd_q.op == bhpq_pkg::OP_INSERT && !presrd_q
					&& count_q < CW'(CAPACITY)) begin
					pres_we    = 1'b1;
					pres_wdata = 1'b1;
				end
			end
			S_RM_ISS: begin
				addr_a = pos_q;
			end
			S_RM_DAT: begin
				pres_we    = 1'b1;
				pres_waddr = ta_q;
			end
			S_UP_ISS: begin
				addr_a = par;
			end
			S_UP_DAT: begin
				if (!above(ka_q, ck_q, order)) begin
					heap_we   = 1'b1;
					heap_wkey = ka_q;
					heap_wtag = ta_q;
				end
			end
			S_DN_ISS: begin
				addr_a = child_a[PW-1:0];
				addr_b = child_b[PW-1:0];
			end
			S_DN_DAT: begin
				if (!above(ck_q, ckey, order)) begin
					heap_we   = 1'b1;
					heap_wkey = ckey;
					heap_wtag = ctag;
				end
			end
			S_PLACE: begin
				heap_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		ka_q     <= key_mem[addr_a];
		ta_q     <= tag_mem[addr_a];
		kb_q     <= key_mem[addr_b];
		tb_q     <= tag_mem[addr_b];
		posrd_q  <= pos_mem[cmd.tag];
		presrd_q <= pres_mem[cmd.tag];
		if (heap_we) begin
			key_mem[heap_waddr] <= heap_wkey;
			tag_mem[heap_waddr] <= heap_wtag;
			pos_mem[heap_wtag]  <= heap_waddr;
		end
		if (pres_we) begin
			pres_mem[pres_waddr] <= pres_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			ck_q        <= '0;
			ct_q        <= '0;
			moved_q     <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + TB'(1);
					if (clr_q == TB'(bhpq_pkg::TAG_SPACE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_take) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					res_q.out_key <= '0;
					res_q.out_tag <= '0;
					moved_q       <= 1'b0;
					if (cmd_q.op == bhpq_pkg::OP_INSERT) begin
						if (presrd_q) begin
							res_q.status     <= bhpq_pkg::ST_DUP;
							res_q.fill_count <= bhpq_pkg::CNT_PORT_BITS'(count_q);
							res_valid_q      <= 1'b1;
							state_q          <= S_IDLE;
						end else if (count_q >= CW'(CAPACITY)) begin
							res_q.status     <= bhpq_pkg::ST_FULL;
							res_q.fill_count <= bhpq_pkg::CNT_PORT_BITS'(count_q);
							res_valid_q      <= 1'b1;
							state_q          <= S_IDLE;
						end else begin
							count_q <= count_q + CW'(1);
							pos_q   <= PW'(count_q);
							ck_q    <= KB'(cmd_q.key);
							ct_q    <= cmd_q.tag;
							state_q <= S_UP_ISS;
						end
					end else if (cmd_q.op == bhpq_pkg::OP_REMOVE_TAG) begin
						if (!presrd_q || CW'(posrd_q) >= count_q) begin
							res_q.status     <= bhpq_pkg::ST_MISS;
							res_q.fill_count <= bhpq_pkg::CNT_PORT_BITS'(count_q);
							res_valid_q      <= 1'b1;
							state_q          <= S_IDLE;
						end else begin
							pos_q   <= posrd_q;
							state_q <= S_RM_ISS;
						end
					end else if (cmd_q.op == bhpq_pkg::OP_REMOVE_ROOT) begin
						if (count_q == '0) begin
							res_q.status     <= bhpq_pkg::ST_MISS;
							res_q.fill_count <= bhpq_pkg::CNT_PORT_BITS'(count_q);
							res_valid_q      <= 1'b1;
							state_q          <= S_IDLE;
						end else begin
							pos_q   <= '0;
							state_q <= S_RM_ISS;
						end
					end else begin
						res_q.fill_count <= bhpq_pkg::CNT_PORT_BITS'(count_q);
						res_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
						if ((CW+TB)'(cmd_q.idx) >= (CW+TB)'(count_q)) begin
							res_q.status <= bhpq_pkg::ST_MISS;
						end else begin
							res_q.status  <= bhpq_pkg::ST_OK;
							res_q.out_key <= bhpq_pkg::KEY_PORT_BITS'(ka_q);
							res_q.out_tag <= ta_q;
						end
					end
				end
				S_RM_ISS: begin
					state_q <= S_RM_DAT;
				end
				S_RM_DAT: begin
					res_q.out_key <= bhpq_pkg::KEY_PORT_BITS'(ka_q);
					res_q.out_tag <= ta_q;
					count_q       <= count_q - CW'(1);
					ck_q          <= kb_q;
					ct_q          <= tb_q;
					if (pos_q == last) begin
						res_q.status     <= bhpq_pkg::ST_OK;
						res_q.fill_count <= bhpq_pkg::CNT_PORT_BITS'(count_q - CW'(1));
						res_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end else begin
						state_q <= S_UP_ISS;
					end
				end
				S_UP_ISS: begin
					if (pos_q == '0) begin
						state_q <= go_down ? S_DN_ISS : S_PLACE;
					end else begin
						state_q <= S_UP_DAT;
					end
				end
				S_UP_DAT: begin
					if (above(ka_q, ck_q, order)) begin
						state_q <= go_down ? S_DN_ISS : S_PLACE;
					end else begin
						pos_q   <= par;
						moved_q <= 1'b1;
						state_q <= S_UP_ISS;
					end
				end
				S_DN_ISS: begin
					state_q <= in_a ? S_DN_DAT : S_PLACE;
				end
				S_DN_DAT: begin
					if (above(ck_q, ckey, order)) begin
						state_q <= S_PLACE;
					end else begin
						pos_q   <= cpos;
						state_q <= S_DN_ISS;
					end
				end
				S_PLACE: begin
					res_q.status     <= bhpq_pkg::ST_OK;
					res_q.fill_count <= bhpq_pkg::CNT_PORT_BITS'(count_q);
					res_valid_q      <= 1'b1;
					state_q          <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[hw/rtl/binary_heap_priority_queue_core.sv]
// Top level of the binary heap priority queue: configuration register and wiring.
//
// Channel    Direction  Handshake                      Payload
// item       in         push / full                    func, entry_key, entry_tag, heap_index
// result     out        pop / empty                    status, out_key, out_tag, fill_count
// config     in         psel, penable, pwrite / pready order_mode at byte address 0
//
// A request enters the front queue when it is accepted and is taken by the engine when the
// engine is idle and the result register is empty; it then goes through lookup, and the
// engine walks the heap one level at a time (one registered memory read, then a compare
// and a write). Insert climbs the heap and removal climbs or descends it, at most
// log2(CAPACITY) levels; a read is answered from lookup without walking the heap.
// After reset the engine clears the 1024-entry tag table, holding full
// high. The engine starts a new request only when the result register is empty, so a
// stalled result side backs up into the two-entry front queue and then into full.
`default_nettype none
module binary_heap_priority_queue_core #(
	parameter int unsigned CAPACITY = bhpq_pkg::CAPACITY_DEF,
	parameter int unsigned KEY_BITS = bhpq_pkg::KEY_BITS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	output logic             full,
	input  bhpq_pkg::item_t  item,
	output logic             empty,
	input  wire              pop,
	output bhpq_pkg::res_t   result,
	input  wire              psel,
	input  wire              penable,
	input  wire              pwrite,
	input  wire  [2:0]       paddr,
	input  wire  [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic                order_q;
	logic                cmd_valid;
	logic                cmd_take;
	bhpq_pkg::cmd_t      cmd;
	bhpq_pkg::eng_ctl_t  ctl;

	// The single register is order_mode, decoded from paddr[2] alone; writes with paddr[2] set are ignored.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'd0, order_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			order_q <= pwdata[0];
		end
	end

	// The front end decodes each request and buffers it for the engine.
	bhpq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.ctl       (ctl),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	// The engine owns the heap, the tag tables and the result register.
	bhpq_engine #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.order     (order_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.ctl       (ctl),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clearing |-> full)
		else $error("request accepted while the tag table is being cleared");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status == bhpq_pkg::ST_FULL)
		|-> result.fill_count == bhpq_pkg::CNT_PORT_BITS'(CAPACITY))
		else $error("full status reported below capacity");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status == bhpq_pkg::ST_MISS)
		|-> (result.out_key == '0 && result.out_tag == '0))
		else $error("miss result carries a nonzero entry");

	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> empty)
		else $error("engine started a request while a result was waiting");

endmodule
`default_nettype wire
